>>> rtl/ttcw_pkg.sv
// Shared types and constants for the text terminal character writer.
// Holds the command codes and the command record passed from the front end to the back end.
// No dependencies.
package ttcw_pkg;

  // Control bytes recognized in the character stream.
  localparam logic [7:0] ChNewline   = 8'd10;
  localparam logic [7:0] ChReturn    = 8'd13;
  localparam logic [7:0] ChBackspace = 8'd8;

  // Configuration register indexes and reset values.
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] RegColumns = 2'd0;
  localparam logic [CfgIdxW-1:0] RegRows    = 2'd1;
  localparam logic [7:0] ColumnsReset = 8'd80;
  localparam logic [5:0] RowsReset    = 6'd26;

  // Lower clamps for the geometry registers.
  localparam logic [8:0] MinColumns = 9'd2;
  localparam logic [6:0] MinRows    = 7'd3;

  // Depth of the command queue between front and back end.
  localparam int unsigned QDepth = 2;

  typedef enum logic [2:0] {
    OP_PRINT,
    OP_NEWLINE,
    OP_RETURN,
    OP_BACKSPACE,
    OP_READ,
    OP_READ_OUTSIDE
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] char_code;
    logic [4:0] read_row;
    logic [6:0] read_col;
  } cmd_t;

endpackage

>>> rtl/text_terminal_char_writer_core.sv
// Top level of the text terminal character writer: configuration registers,
// front end with command queue, and back end with the cell store.
// Depends on ttcw_pkg, ttcw_front and ttcw_back.
//
// After reset the cell store is cleared, one cell per cycle, over all MAX_ROWS * MAX_COLUMNS
// cells (4096 at the defaults); full stays high during that pass, while configuration
// writes are taken as always. Requests enter a two-entry command queue and are executed
// in order by the back end, which holds one finished result in its output register.
// Control bytes, printable bytes without scroll and reads outside the store finish in
// the idle state; a read inside the store also waits for the registered read port. A
// printable byte that scrolls first copies the rows in use up by one row, one cell copied
// per cycle through the single write port of the store, and then writes the byte.
module text_terminal_char_writer_core
  import ttcw_pkg::*;
#(
  parameter int unsigned MAX_COLUMNS = 128,
  parameter int unsigned MAX_ROWS    = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic               kind_i,
  input  logic [7:0]         char_code_i,
  input  logic [4:0]         read_row_i,
  input  logic [6:0]         read_col_i,
  output logic               empty,
  input  logic               pop,
  output logic [7:0]         cell_value_o,
  output logic [4:0]         cursor_row_o,
  output logic [7:0]         cursor_col_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [7:0]         cfg_data_i
);

  logic [7:0] columns_q;
  logic [5:0] rows_q;
  logic       clearing;
  logic       cmd_valid, cmd_pop;
  cmd_t       cmd;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      columns_q <= ColumnsReset;
      rows_q    <= RowsReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        RegColumns: columns_q <= cfg_data_i;
        RegRows:    rows_q    <= cfg_data_i[5:0];
        default: begin
        end
      endcase
    end
  end

  ttcw_front #(
    .MAX_COLUMNS(MAX_COLUMNS),
    .MAX_ROWS   (MAX_ROWS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .full_o     (full),
    .kind_i     (kind_i),
    .char_code_i(char_code_i),
    .read_row_i (read_row_i),
    .read_col_i (read_col_i),
    .clearing_i (clearing),
    .cmd_valid_o(cmd_valid),
    .cmd_o      (cmd),
    .cmd_pop_i  (cmd_pop)
  );

  ttcw_back #(
    .MAX_COLUMNS(MAX_COLUMNS),
    .MAX_ROWS   (MAX_ROWS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .clearing_o  (clearing),
    .columns_i   (columns_q),
    .rows_i      (rows_q),
    .res_pop_i   (pop),
    .res_empty_o (empty),
    .cell_value_o(cell_value_o),
    .cursor_row_o(cursor_row_o),
    .cursor_col_o(cursor_col_o)
  );

endmodule

>>> rtl/ttcw_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
module ttcw_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> rtl/ttcw_front.sv
// Front end of the text terminal character writer: accepts requests, classifies them
// into commands and buffers them in a short queue. Depends on ttcw_pkg.
module ttcw_front
  import ttcw_pkg::*;
#(
  parameter int unsigned MAX_COLUMNS = 128,
  parameter int unsigned MAX_ROWS    = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  output logic       full_o,
  input  logic       kind_i,
  input  logic [7:0] char_code_i,
  input  logic [4:0] read_row_i,
  input  logic [6:0] read_col_i,
  input  logic       clearing_i,
  output logic       cmd_valid_o,
  output cmd_t       cmd_o,
  input  logic       cmd_pop_i
);

  localparam int unsigned PtrW = $clog2(QDepth);
  localparam int unsigned CntW = $clog2(QDepth + 1);

  cmd_t            q_q [QDepth];
  cmd_t            cmd_new;
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q, count_d;
  logic            push_acc, pop_acc;

  // Sort the request into one of the back end's commands.
  always_comb begin
    cmd_new.char_code = char_code_i;
    cmd_new.read_row  = read_row_i;
    cmd_new.read_col  = read_col_i;
    if (kind_i) begin
      if ((32'(read_row_i) < MAX_ROWS) && (32'(read_col_i) < MAX_COLUMNS)) begin
        cmd_new.op = OP_READ;
      end else begin
        cmd_new.op = OP_READ_OUTSIDE;
      end
    end else begin
      unique case (char_code_i)
        ChNewline:   cmd_new.op = OP_NEWLINE;
        ChReturn:    cmd_new.op = OP_RETURN;
        ChBackspace: cmd_new.op = OP_BACKSPACE;
        default:     cmd_new.op = OP_PRINT;
      endcase
    end
  end

  assign full_o      = (count_q == CntW'(QDepth)) || clearing_i;
  assign push_acc    = push_i && !full_o;
  assign cmd_valid_o = (count_q != '0);
  assign pop_acc     = cmd_pop_i && cmd_valid_o;
  assign cmd_o       = q_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push_acc && !pop_acc) begin
      count_d = count_q + CntW'(1);
    end else if (pop_acc && !push_acc) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (push_acc) begin
        wr_ptr_q <= wr_ptr_q + PtrW'(1);
      end
      if (pop_acc) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_acc) begin
      q_q[wr_ptr_q] <= cmd_new;
    end
  end

endmodule

>>> rtl/ttcw_back.sv
// Back end of the text terminal character writer: cursor, cell store, scroll copy engine
// and the result register. Depends on ttcw_pkg and ttcw_ram.
module ttcw_back
  import ttcw_pkg::*;
#(
  parameter int unsigned MAX_COLUMNS = 128,
  parameter int unsigned MAX_ROWS    = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cmd_valid_i,
  input  cmd_t       cmd_i,
  output logic       cmd_pop_o,
  output logic       clearing_o,
  input  logic [7:0] columns_i,
  input  logic [5:0] rows_i,
  input  logic       res_pop_i,
  output logic       res_empty_o,
  output logic [7:0] cell_value_o,
  output logic [4:0] cursor_row_o,
  output logic [7:0] cursor_col_o
);

  localparam int unsigned Depth = MAX_ROWS * MAX_COLUMNS;
  localparam int unsigned AW    = $clog2(Depth);
  localparam int unsigned RW    = $clog2(MAX_ROWS);
  localparam int unsigned RW1   = $clog2(MAX_ROWS + 1);
  localparam int unsigned CW    = $clog2(MAX_COLUMNS + 1);
  localparam logic [AW-1:0]  RowPitch = AW'(MAX_COLUMNS);
  localparam logic [AW-1:0]  LastAddr = AW'(Depth - 1);
  localparam logic [CW-1:0]  ColsMax  = CW'(MAX_COLUMNS);
  localparam logic [RW1-1:0] RowsMax  = RW1'(MAX_ROWS);

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_READ   = 3'd2;
  localparam logic [2:0] S_SCROLL = 3'd3;
  localparam logic [2:0] S_DRAIN  = 3'd4;
  localparam logic [2:0] S_PUT    = 3'd5;

  function automatic logic [AW-1:0] cell_addr(logic [AW-1:0] row, logic [AW-1:0] col);
    return row * RowPitch + col;
  endfunction

  logic [2:0]     state_q, state_d;
  logic [RW-1:0]  row_q, row_d;
  logic [CW-1:0]  col_q, col_d;
  logic [AW-1:0]  clr_addr_q, clr_addr_d;
  logic [RW-1:0]  cp_row_q, cp_row_d;
  logic [CW-1:0]  cp_col_q, cp_col_d;
  logic [AW-1:0]  cp_base_q, cp_base_d;
  logic           cp_wr_pend_q, cp_wr_pend_d;
  logic [AW-1:0]  cp_wr_addr_q, cp_wr_addr_d;
  logic [7:0]     put_char_q, put_char_d;
  logic           res_valid_q;
  logic [7:0]     res_cell_q, res_cell_d;
  logic [4:0]     res_row_q;
  logic [7:0]     res_col_q;

  logic [8:0]     cols_ext;
  logic [6:0]     rows_ext;
  logic [CW-1:0]  ncols;
  logic [RW1-1:0] nrows;
  logic [RW1-1:0] row_x, prow;
  logic [CW-1:0]  pcol, bs_col;
  logic           wrap, need_scroll;
  logic           res_free, res_load, pop_acc;
  logic           st_we;
  logic [AW-1:0]  st_waddr;
  logic [7:0]     st_wdata;
  logic           ram_we;
  logic [AW-1:0]  ram_waddr, rd_addr;
  logic [7:0]     ram_wdata, rd_data;

  // Geometry in use, clamped between the lower clamps and what the store can hold.
  assign cols_ext = {1'b0, columns_i};
  assign rows_ext = {1'b0, rows_i};

  always_comb begin
    if (cols_ext < MinColumns) begin
      ncols = CW'(MinColumns);
    end else if (cols_ext > 9'(MAX_COLUMNS)) begin
      ncols = ColsMax;
    end else begin
      ncols = CW'(cols_ext);
    end
    if (rows_ext < MinRows) begin
      nrows = RW1'(MinRows);
    end else if (rows_ext > 7'(MAX_ROWS)) begin
      nrows = RowsMax;
    end else begin
      nrows = RW1'(rows_ext);
    end
  end

  // A printable byte first wraps when the cursor stands at or past the column limit.
  assign row_x       = RW1'(row_q);
  assign wrap        = (col_q >= ncols);
  assign pcol        = wrap ? '0 : col_q;
  assign prow        = wrap ? row_x + RW1'(1) : row_x;
  assign need_scroll = (prow >= nrows - RW1'(1));
  assign bs_col      = col_q - CW'(1);

  assign pop_acc  = res_pop_i && res_valid_q;
  assign res_free = !res_valid_q || res_pop_i;

  always_comb begin
    state_d      = state_q;
    row_d        = row_q;
    col_d        = col_q;
    clr_addr_d   = clr_addr_q;
    cp_row_d     = cp_row_q;
    cp_col_d     = cp_col_q;
    cp_base_d    = cp_base_q;
    cp_wr_pend_d = 1'b0;
    cp_wr_addr_d = cp_base_q + AW'(cp_col_q);
    put_char_d   = put_char_q;
    cmd_pop_o    = 1'b0;
    res_load     = 1'b0;
    res_cell_d   = '0;
    st_we        = 1'b0;
    st_waddr     = '0;
    st_wdata     = '0;
    rd_addr      = cell_addr(AW'(cmd_i.read_row), AW'(cmd_i.read_col));

    unique case (state_q)
      S_CLEAR: begin
        st_we      = 1'b1;
        st_waddr   = clr_addr_q;
        clr_addr_d = clr_addr_q + AW'(1);
        if (clr_addr_q == LastAddr) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (cmd_valid_i && res_free) begin
          cmd_pop_o = 1'b1;
          unique case (cmd_i.op)
            OP_NEWLINE: begin
              if (row_x + RW1'(1) < nrows) begin
                row_d = RW'(row_x + RW1'(1));
              end else begin
                row_d = RW'(nrows - RW1'(1));
              end
              col_d    = '0;
              res_load = 1'b1;
            end
            OP_RETURN: begin
              col_d    = '0;
              res_load = 1'b1;
            end
            OP_BACKSPACE: begin
              res_load = 1'b1;
              if (col_q != '0) begin
                col_d = bs_col;
                if ((bs_col < ncols) && (row_x < nrows)) begin
                  st_we    = 1'b1;
                  st_waddr = cell_addr(AW'(row_q), AW'(bs_col));
                end
              end
            end
            OP_PRINT: begin
              col_d = pcol;
              if (need_scroll) begin
                put_char_d = cmd_i.char_code;
                cp_row_d   = '0;
                cp_col_d   = '0;
                cp_base_d  = '0;
                state_d    = S_SCROLL;
              end else begin
                st_we    = 1'b1;
                st_waddr = cell_addr(AW'(prow), AW'(pcol));
                st_wdata = cmd_i.char_code;
                row_d    = RW'(prow);
                col_d    = pcol + CW'(1);
                res_load = 1'b1;
              end
            end
            OP_READ: begin
              state_d = S_READ;
            end
            default: begin
              res_load = 1'b1;
            end
          endcase
        end
      end
      S_READ: begin
        res_load   = 1'b1;
        res_cell_d = rd_data;
        state_d    = S_IDLE;
      end
      S_SCROLL: begin
        // Read one cell of the row below; it is written one row up in the next cycle.
        rd_addr      = cp_base_q + RowPitch + AW'(cp_col_q);
        cp_wr_pend_d = 1'b1;
        if (cp_col_q == ncols - CW'(1)) begin
          cp_col_d  = '0;
          cp_base_d = cp_base_q + RowPitch;
          cp_row_d  = cp_row_q + RW'(1);
          if (RW1'(cp_row_q) == nrows - RW1'(2)) begin
            state_d = S_DRAIN;
          end
        end else begin
          cp_col_d = cp_col_q + CW'(1);
        end
      end
      S_DRAIN: begin
        state_d = S_PUT;
      end
      S_PUT: begin
        st_we    = 1'b1;
        st_waddr = cell_addr(AW'(nrows - RW1'(2)), AW'(col_q));
        st_wdata = put_char_q;
        row_d    = RW'(nrows - RW1'(2));
        col_d    = col_q + CW'(1);
        res_load = 1'b1;
        state_d  = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // The pending copy write has the port whenever it is due.
  assign ram_we    = cp_wr_pend_q || st_we;
  assign ram_waddr = cp_wr_pend_q ? cp_wr_addr_q : st_waddr;
  assign ram_wdata = cp_wr_pend_q ? rd_data : st_wdata;

  ttcw_ram #(
    .Width(8),
    .Depth(Depth)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(rd_addr),
    .rdata_o(rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      row_q        <= '0;
      col_q        <= '0;
      clr_addr_q   <= '0;
      cp_row_q     <= '0;
      cp_col_q     <= '0;
      cp_base_q    <= '0;
      cp_wr_pend_q <= 1'b0;
      res_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      row_q        <= row_d;
      col_q        <= col_d;
      clr_addr_q   <= clr_addr_d;
      cp_row_q     <= cp_row_d;
      cp_col_q     <= cp_col_d;
      cp_base_q    <= cp_base_d;
      cp_wr_pend_q <= cp_wr_pend_d;
      res_valid_q  <= (res_valid_q && !pop_acc) || res_load;
    end
  end

  always_ff @(posedge clk_i) begin
    cp_wr_addr_q <= cp_wr_addr_d;
    put_char_q   <= put_char_d;
    if (res_load) begin
      res_cell_q <= res_cell_d;
      res_row_q  <= 5'(row_d);
      res_col_q  <= 8'(col_d);
    end
  end

  assign clearing_o   = (state_q == S_CLEAR);
  assign res_empty_o  = !res_valid_q;
  assign cell_value_o = res_cell_q;
  assign cursor_row_o = res_row_q;
  assign cursor_col_o = res_col_q;

`ifndef SYNTHESIS
  a_scroll_slot_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCROLL || state_q == S_DRAIN) |-> !res_valid_q)
    else $error("result slot filled during a scroll");

  a_copy_write_in_scroll : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cp_wr_pend_q |-> (state_q == S_SCROLL || state_q == S_DRAIN))
    else $error("copy write outside a scroll");

  a_no_result_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_load |-> (!res_valid_q || res_pop_i))
    else $error("result overwritten before it was taken");

  a_no_dispatch_when_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |=> (state_q != S_CLEAR))
    else $error("command taken while the store is being cleared");
`endif

endmodule
